@@ hw/rtl/dpc_pkg.sv @@
`timescale 1ns / 1ps

package dpc_pkg;

	localparam int NODE_SLOTS = 4096;
	localparam int REF_W      = 12;
	localparam int CNT_W      = 64;
	localparam int HALF_W     = CNT_W / 2;
	localparam int ADDR_W     = $clog2(NODE_SLOTS);
	localparam int NEXT_W     = ADDR_W + 1;
	localparam int CMP_W      = (REF_W > NEXT_W) ? REF_W : NEXT_W;

	typedef enum logic [1:0] {
		KIND_APPEND  = 2'd0,
		KIND_UNION   = 2'd1,
		KIND_PRODUCT = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_REF  = 2'd1,
		ST_BAD_KIND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_LEFT,
		S_RD_RIGHT,
		S_MUL_LO,
		S_MUL_CROSS,
		S_COMBINE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             first_node;
		logic [1:0]       node_kind;
		logic [REF_W-1:0] left_ref;
		logic [REF_W-1:0] right_ref;
	} node_beat_t;

	typedef struct packed {
		logic [REF_W-1:0] node_ref;
		logic [CNT_W-1:0] path_count;
		logic             saturated;
		logic [1:0]       status;
		logic             graph_failed;
	} result_beat_t;

endpackage

@@ hw/rtl/dag_path_count_engine.sv @@
`timescale 1ns / 1ps

// Path counter for a topologically ordered append/union/product graph, one node per beat.
// Each node is assigned the next reference (from 2) and its 64-bit saturated count is
// emitted and kept in a 4096-entry count memory for later nodes. Each node reads its left
// then right child; a union then adds them in a combine step, a product runs low, cross
// and combine steps, and a node dropped on a full table skips the reads; the input is not
// taken again until the node is done. The steps follow from the single read port of the
// count memory and from the one 32x32 multiplier and 65-bit adder, reused for the low,
// cross and combining steps of the product. A finished result waits in an output
// register, so the next node is accepted while it is still stalled.
module dag_path_count_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  node_valid,
	output logic                  node_stall,
	input  dpc_pkg::node_beat_t   node,
	output logic                  result_valid,
	input  logic                  result_stall,
	output dpc_pkg::result_beat_t result
);

	import dpc_pkg::*;

	state_t            state_q, state_d;
	logic [NEXT_W-1:0] next_ref_q, eff_next;
	logic              failed_q;
	logic              accept, full, bad_ref, out_free;
	status_t           status_in, status_q;
	kind_t             kind_q;
	logic [REF_W-1:0]  lref_q, rref_q, me_q;
	logic [CNT_W-1:0]  a_q, b_q, lo_q, p_q, res_q, fetched;
	logic              ovf_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [CNT_W-1:0]  rd_data;
	logic              wr_en;
	logic [HALF_W-1:0] mul_x, mul_y;
	logic [CNT_W-1:0]  add_x, add_y;
	logic [CNT_W:0]    sum;
	logic              a_hi_nz, b_hi_nz, sat_comb;
	logic [REF_W-1:0]  fetch_ref;

	assign node_stall = (state_q != S_IDLE);
	assign accept     = node_valid && !node_stall;
	assign out_free   = !result_valid || !result_stall;

	assign eff_next = node.first_node ? NEXT_W'(2) : next_ref_q;
	assign full     = (CMP_W'(eff_next) >= CMP_W'(NODE_SLOTS));
	assign bad_ref  = (CMP_W'(node.left_ref) >= CMP_W'(eff_next))
		|| ((node.node_kind != KIND_APPEND) && (CMP_W'(node.right_ref) >= CMP_W'(eff_next)));

	always_comb begin
		priority if (full) begin
			status_in = ST_FULL;
		end else if (bad_ref) begin
			status_in = ST_BAD_REF;
		end else if (node.node_kind == KIND_UNKNOWN) begin
			status_in = ST_BAD_KIND;
		end else begin
			status_in = ST_OK;
		end
	end

	always_comb begin
		fetch_ref = (state_q == S_RD_LEFT) ? lref_q : rref_q;
		priority if (fetch_ref == REF_W'(0)) begin
			fetched = '0;
		end else if (fetch_ref == REF_W'(1)) begin
			fetched = CNT_W'(1);
		end else begin
			fetched = rd_data;
		end
	end

	assign a_hi_nz = (a_q[CNT_W-1:HALF_W] != '0);
	assign b_hi_nz = (b_q[CNT_W-1:HALF_W] != '0);

	always_comb begin
		if (state_q == S_MUL_LO) begin
			mul_x = a_q[HALF_W-1:0];
			mul_y = b_q[HALF_W-1:0];
		end else if (a_hi_nz) begin
			mul_x = a_q[CNT_W-1:HALF_W];
			mul_y = b_q[HALF_W-1:0];
		end else begin
			mul_x = a_q[HALF_W-1:0];
			mul_y = b_q[CNT_W-1:HALF_W];
		end
	end

	always_comb begin
		if (kind_q == KIND_UNION) begin
			add_x = a_q;
			add_y = b_q;
		end else begin
			add_x = lo_q;
			add_y = {p_q[HALF_W-1:0], {HALF_W{1'b0}}};
		end
		sum      = {1'b0, add_x} + {1'b0, add_y};
		sat_comb = sum[CNT_W] || ((kind_q == KIND_PRODUCT)
			&& (ovf_q || (p_q[CNT_W-1:HALF_W] != '0)));
	end

	always_comb begin
		state_d = state_q;
		rd_addr = ADDR_W'(rref_q);
		wr_en   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = ADDR_W'(node.left_ref);
				if (accept) begin
					state_d = (status_in == ST_FULL) ? S_FINISH : S_RD_LEFT;
				end
			end
			S_RD_LEFT: begin
				state_d = S_RD_RIGHT;
			end
			S_RD_RIGHT: begin
				if (status_q != ST_OK || kind_q == KIND_APPEND) begin
					state_d = S_FINISH;
				end else if (kind_q == KIND_UNION) begin
					state_d = S_COMBINE;
				end else begin
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: begin
				state_d = S_MUL_CROSS;
			end
			S_MUL_CROSS: begin
				state_d = S_COMBINE;
			end
			S_COMBINE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					wr_en   = (status_q != ST_FULL);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_ref_q   <= NEXT_W'(2);
			failed_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				next_ref_q <= full ? eff_next : eff_next + NEXT_W'(1);
				failed_q   <= (failed_q && !node.first_node) || (status_in != ST_OK);
			end
			if (state_q == S_FINISH && out_free) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= CNT_W'(mul_x) * CNT_W'(mul_y);
		if (accept) begin
			kind_q   <= kind_t'(node.node_kind);
			lref_q   <= node.left_ref;
			rref_q   <= node.right_ref;
			me_q     <= full ? '0 : REF_W'(eff_next);
			status_q <= status_in;
			res_q    <= '0;
		end
		if (state_q == S_RD_LEFT) begin
			a_q <= fetched;
		end
		if (state_q == S_RD_RIGHT) begin
			b_q <= fetched;
			if (status_q == ST_OK && kind_q == KIND_APPEND) begin
				res_q <= a_q;
			end
		end
		if (state_q == S_MUL_LO) begin
			ovf_q <= a_hi_nz && b_hi_nz;
		end
		if (state_q == S_MUL_CROSS) begin
			lo_q <= p_q;
		end
		if (state_q == S_COMBINE) begin
			res_q <= sat_comb ? '1 : sum[CNT_W-1:0];
		end
		if (state_q == S_FINISH && out_free) begin
			result.node_ref     <= me_q;
			result.path_count   <= res_q;
			result.saturated    <= (res_q == '1);
			result.status       <= status_q;
			result.graph_failed <= failed_q;
		end
	end

	dpc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NODE_SLOTS)
	) u_count_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ADDR_W'(me_q)),
		.wr_data(res_q),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

@@ hw/rtl/dpc_ram.sv @@
`timescale 1ns / 1ps

module dpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ sim/tb_dag_path_count_engine.sv @@
`timescale 1ns / 1ps

module tb_dag_path_count_engine;
	import dpc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_NODES = 1030;
	localparam int CALM_TAIL = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic node_valid = 1'b0;
	logic node_stall;
	node_beat_t node = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_beat_t result;

	node_beat_t pend_q[$];
	result_beat_t count_q[$];
	result_beat_t want;

	bit [CNT_W-1:0] count_mem [NODE_SLOTS];
	logic [NEXT_W-1:0] next_ref = NEXT_W'(2);
	logic graph_bad = 1'b0;
	int gen_next = 2;

	int fail_cnt = 0;
	int got_cnt = 0;
	int tx_gap = 0;
	int tx_rate = 10;
	int rx_gap = 0;
	int rx_rate = 10;
	int hold_left = 0;
	bit pressured = 1'b0;
	int quiet_run = 0;

	dag_path_count_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_valid   (node_valid),
		.node_stall   (node_stall),
		.node         (node),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] ref_count(input logic [REF_W-1:0] r);
		if (r == 0)
			return '0;
		if (r == 1)
			return CNT_W'(1);
		return count_mem[r];
	endfunction

	function automatic result_beat_t count_paths(input node_beat_t n);
		logic [2*CNT_W-1:0] prod;
		logic [CNT_W:0] sum;
		logic [CNT_W-1:0] lc;
		logic [CNT_W-1:0] rc;
		logic [CNT_W-1:0] cnt;
		logic [NEXT_W-1:0] me;
		status_t st;
		result_beat_t r;
		r = '0;
		if (n.first_node) begin
			next_ref = NEXT_W'(2);
			graph_bad = 1'b0;
		end
		if (next_ref >= NODE_SLOTS) begin
			graph_bad = 1'b1;
			r.status = ST_FULL;
			r.graph_failed = 1'b1;
			return r;
		end
		me = next_ref;
		cnt = '0;
		st = ST_OK;
		if (n.left_ref >= me || (n.node_kind != KIND_APPEND && n.right_ref >= me)) begin
			st = ST_BAD_REF;
		end else begin
			lc = ref_count(n.left_ref);
			rc = ref_count(n.right_ref);
			case (n.node_kind)
				KIND_APPEND: begin
					cnt = lc;
				end
				KIND_UNION: begin
					sum = {1'b0, lc} + {1'b0, rc};
					cnt = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
				end
				KIND_PRODUCT: begin
					prod = {{CNT_W{1'b0}}, lc} * {{CNT_W{1'b0}}, rc};
					cnt = (|prod[2*CNT_W-1:CNT_W]) ? '1 : prod[CNT_W-1:0];
				end
				default: begin
					st = ST_BAD_KIND;
				end
			endcase
		end
		if (st != ST_OK)
			graph_bad = 1'b1;
		count_mem[me[ADDR_W-1:0]] = cnt;
		next_ref = next_ref + 1'b1;
		r.node_ref = me[REF_W-1:0];
		r.path_count = cnt;
		r.saturated = (cnt == '1);
		r.status = st;
		r.graph_failed = graph_bad;
		return r;
	endfunction

	task automatic add_node(input logic f, input logic [1:0] k, input logic [REF_W-1:0] l,
			input logic [REF_W-1:0] r);
		node_beat_t n;
		n.first_node = f;
		n.node_kind = k;
		n.left_ref = l;
		n.right_ref = r;
		pend_q.push_back(n);
		if (f)
			gen_next = 2;
		if (gen_next < NODE_SLOTS)
			gen_next++;
	endtask

	function automatic logic [REF_W-1:0] pick_ref(input int me);
		int p;
		int span;
		p = $urandom_range(0, 99);
		if (me <= 2)
			return REF_W'($urandom_range(0, 1));
		span = (me - 3 < 7) ? me - 3 : 7;
		if (p < 4)
			return '0;
		if (p < 12)
			return REF_W'(1);
		if (p < 65)
			return REF_W'(me - 1 - $urandom_range(0, span));
		return REF_W'($urandom_range(2, me - 1));
	endfunction

	function automatic kind_t pick_kind();
		int p;
		p = $urandom_range(0, 99);
		if (p < 25)
			return KIND_APPEND;
		if (p < 60)
			return KIND_UNION;
		return KIND_PRODUCT;
	endfunction

	task automatic check_field(input string fname, input logic [CNT_W-1:0] want_v,
			input logic [CNT_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", fname, want_v, got_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_valid <= 1'b0;
			node <= '0;
		end else begin
			if (node_valid && !node_stall)
				count_q.push_back(count_paths(node));
			if (!node_valid || !node_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					node_valid <= 1'b0;
				end else if (pend_q.size() == 0) begin
					node_valid <= 1'b0;
				end else if (pend_q.size() > CALM_TAIL && $urandom_range(0, 99) < tx_rate) begin
					tx_gap = $urandom_range(1, 13) - 1;
					node_valid <= 1'b0;
				end else begin
					if ($urandom_range(0, 63) == 0) begin
						case ($urandom_range(0, 2))
							0: tx_rate = 0;
							1: tx_rate = 8;
							default: tx_rate = 30;
						endcase
					end
					node <= pend_q.pop_front();
					node_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (count_q.size() == 0) begin
					$error("result beat with nothing expected: node_ref %0d", result.node_ref);
					fail_cnt++;
				end else begin
					want = count_q.pop_front();
					check_field("node_ref", CNT_W'(want.node_ref), CNT_W'(result.node_ref));
					check_field("path_count", want.path_count, result.path_count);
					check_field("saturated", CNT_W'(want.saturated), CNT_W'(result.saturated));
					check_field("status", CNT_W'(want.status), CNT_W'(result.status));
					check_field("graph_failed", CNT_W'(want.graph_failed),
						CNT_W'(result.graph_failed));
				end
				got_cnt++;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!pressured && got_cnt >= 300) begin
				pressured = 1'b1;
				hold_left = 119;
				result_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				result_stall <= 1'b1;
			end else if (pend_q.size() > CALM_TAIL && $urandom_range(0, 99) < rx_rate) begin
				rx_gap = $urandom_range(1, 13) - 1;
				result_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 63) == 0) begin
					case ($urandom_range(0, 2))
						0: rx_rate = 0;
						1: rx_rate = 8;
						default: rx_rate = 30;
					endcase
				end
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((node_valid && !node_stall) || (result_valid && !result_stall)) begin
				quiet_run <= 0;
			end else if (quiet_run >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_run <= quiet_run + 1;
			end
		end
	end

	initial begin
		int i;
		int glen;
		int gen_total;
		int me;
		logic f;
		kind_t k;
		logic [REF_W-1:0] l;
		logic [REF_W-1:0] r;

		add_node(1'b0, KIND_APPEND, 12'd1, 12'd4095);
		add_node(1'b0, KIND_UNION, 12'd1, 12'd1);
		add_node(1'b0, KIND_PRODUCT, 12'd3, 12'd3);
		add_node(1'b0, KIND_PRODUCT, 12'd4, 12'd4);
		add_node(1'b0, KIND_PRODUCT, 12'd5, 12'd5);
		add_node(1'b0, KIND_PRODUCT, 12'd6, 12'd6);
		add_node(1'b0, KIND_PRODUCT, 12'd7, 12'd7);
		add_node(1'b0, KIND_PRODUCT, 12'd8, 12'd8);
		add_node(1'b0, KIND_UNION, 12'd9, 12'd2);
		add_node(1'b0, KIND_PRODUCT, 12'd9, 12'd0);
		add_node(1'b0, KIND_APPEND, 12'd0, 12'd0);
		add_node(1'b0, KIND_UNION, 12'd0, 12'd1);
		add_node(1'b0, KIND_APPEND, 12'd14, 12'd0);
		add_node(1'b0, KIND_UNION, 12'd2, 12'd15);
		add_node(1'b0, KIND_PRODUCT, 12'd4095, 12'd2);
		add_node(1'b0, KIND_UNKNOWN, 12'd2, 12'd3);
		add_node(1'b0, KIND_UNKNOWN, 12'd2, 12'd4095);
		add_node(1'b0, KIND_UNION, 12'd8, 12'd8);
		add_node(1'b1, KIND_PRODUCT, 12'd1, 12'd1);
		add_node(1'b1, KIND_UNKNOWN, 12'd0, 12'd0);
		add_node(1'b1, KIND_APPEND, 12'd1, 12'd4095);
		add_node(1'b0, KIND_UNION, 12'd2, 12'd2);

		add_node(1'b1, KIND_UNION, 12'd1, 12'd1);

		gen_total = 0;
		while (gen_total < RANDOM_NODES) begin
			glen = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 60);
			if (glen > RANDOM_NODES - gen_total)
				glen = RANDOM_NODES - gen_total;
			for (i = 0; i < glen; i++) begin
				f = (i == 0);
				me = f ? 2 : gen_next;
				k = pick_kind();
				l = pick_ref(me);
				r = (k == KIND_APPEND && $urandom_range(0, 1)) ? REF_W'($urandom) : pick_ref(me);
				if ($urandom_range(0, 99) < 12) begin
					case ($urandom_range(0, 3))
						0: k = KIND_UNKNOWN;
						1: l = REF_W'($urandom);
						2: begin
							r = REF_W'($urandom);
							k = ($urandom_range(0, 1)) ? KIND_UNION : KIND_PRODUCT;
						end
						default: begin
							f = 1'b1;
							k = kind_t'($urandom_range(0, 3));
							l = REF_W'($urandom);
							r = REF_W'($urandom);
						end
					endcase
				end
				add_node(f, k, l, r);
				gen_total++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || node_valid)
			@(posedge clk);
		while (count_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/dpc_pkg.sv
hw/rtl/dpc_ram.sv
hw/rtl/dag_path_count_engine.sv
sim/tb_dag_path_count_engine.sv
